>>> design/pat_pkg.sv
// shared types and constants for the paged address translator
// no dependencies; used by every module of the block

package pat_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = 16;
  localparam int DIV_STEPS   = ADDR_W;
  // result queue depth, power of two, larger than the pipeline latency
  localparam int OUT_DEPTH   = 32;

  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  localparam logic CFG_PAGE_SIZE    = 1'b0;
  localparam logic CFG_PROCESS_SIZE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [6:0]  page_index;
    logic [7:0]  frame_value;
    logic [15:0] logical_address;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [15:0] quot;
    logic [15:0] rem;
  } div_work_t;

  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } tbl_req_t;

  typedef struct packed {
    logic [15:0] page_number;
    logic [15:0] page_offset;
    logic [7:0]  frame_number;
    logic [23:0] physical_address;
    logic        out_of_range;
  } result_t;

endpackage

>>> design/pat_divider.sv
// pipelined restoring divider, one quotient bit per stage
// carries the whole item alongside; depends on pat_pkg

module pat_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pat_pkg::item_t      in_item,
  input  logic [15:0]         divisor,
  output logic                out_valid,
  output pat_pkg::div_work_t  out_work
);

  localparam int N = pat_pkg::DIV_STEPS;

  function automatic pat_pkg::div_work_t div_step(input pat_pkg::div_work_t w,
                                                  input logic [15:0] d,
                                                  input logic dbit);
    logic [16:0]        trial;
    pat_pkg::div_work_t r;
    r     = w;
    trial = {w.rem, dbit};
    if (trial >= {1'b0, d}) begin
      r.rem  = 16'(trial - {1'b0, d});
      r.quot = {w.quot[14:0], 1'b1};
    end else begin
      r.rem  = trial[15:0];
      r.quot = {w.quot[14:0], 1'b0};
    end
    return r;
  endfunction

  logic [N-1:0]        st_valid;
  pat_pkg::div_work_t  st_work [N];
  pat_pkg::div_work_t  src_work [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else begin
      st_valid <= {st_valid[N-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    if (k == 0) begin : g_first
      assign src_work[k] = '{item: in_item, quot: '0, rem: '0};
    end else begin : g_next
      assign src_work[k] = st_work[k-1];
    end

    always_ff @(posedge clk) begin
      st_work[k] <= div_step(src_work[k], divisor,
                             src_work[k].item.logical_address[N-1-k]);
    end
  end

  assign out_valid = st_valid[N-1];
  assign out_work  = st_work[N-1];

endmodule

>>> design/pat_frame_table.sv
// frame table: single-port synchronous ram, registered read
// one access per cycle, write or read; depends on pat_pkg

module pat_frame_table #(
  parameter int TABLE_DEPTH = pat_pkg::TABLE_DEPTH
) (
  input  logic               clk,
  input  pat_pkg::tbl_req_t  req,
  output logic [7:0]         rd_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [7:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

>>> design/pat_out_fifo.sv
// result queue between the translate pipeline and the output channel
// head entry is shown directly; depends on pat_pkg

module pat_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pat_pkg::result_t  wdata,
  input  logic              pop,
  output logic              valid,
  output pat_pkg::result_t  rdata
);

  localparam int PW = $clog2(pat_pkg::OUT_DEPTH);
  localparam int CW = $clog2(pat_pkg::OUT_DEPTH + 1);

  pat_pkg::result_t q [pat_pkg::OUT_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assign valid = (count != '0);
  assign rdata = q[rd_ptr];

endmodule

>>> design/paged_address_translator_core.sv
// paged address translator, top level
// depends on pat_pkg, pat_divider, pat_frame_table, pat_out_fifo
//
// input channel (in_valid / in_stall) takes one item per cycle while in_stall
// is low: command 0 writes frame_value into the frame table at page_index
// (ignored beyond the table depth, no result), command 1 translates
// logical_address and gives one result on the output channel (out_valid /
// out_stall). page_size and process_size are written through cfg_write /
// cfg_index / cfg_data; the user must write them only while no item is in
// flight, the block itself does not enforce this. throughput is one item per
// cycle while in_stall is low. a translation passes through the divider
// pipeline (one quotient bit per stage), then a registered frame table ram
// read alongside the range check, then the frame times page size multiply-add
// into the result queue. the result queue holds 32 items; in_stall rises when
// 32 translations are accepted and not yet taken, so a stalled receiver fills
// the queue first and the pipeline itself never stops. writes reach the ram in
// order with translations in the same pipeline stage, so no forwarding is needed.
// reset (rst, synchronous) empties the pipeline and queue and sets
// page_size to 1 and process_size to 0; frame table contents are undefined
// until written.

module paged_address_translator_core #(
  parameter int TABLE_DEPTH = pat_pkg::TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [6:0]  page_index,
  input  logic [7:0]  frame_value,
  input  logic [15:0] logical_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] page_number,
  output logic [15:0] page_offset,
  output logic [7:0]  frame_number,
  output logic [23:0] physical_address,
  output logic        out_of_range
);

  localparam int CW = $clog2(pat_pkg::OUT_DEPTH + 1);
  localparam logic [15:0] DEPTH16 = 16'(TABLE_DEPTH);

  logic [15:0] page_size;
  logic [15:0] process_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size    <= 16'd1;
      process_size <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        pat_pkg::CFG_PAGE_SIZE:    page_size    <= cfg_data;
        pat_pkg::CFG_PROCESS_SIZE: process_size <= cfg_data;
        default: ;
      endcase
    end
  end

  logic               in_accept;
  logic               out_pop;
  logic [CW-1:0]      credits;
  pat_pkg::item_t     in_item;

  assign in_stall  = (credits == CW'(pat_pkg::OUT_DEPTH));
  assign in_accept = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;
  assign in_item   = '{command: command, page_index: page_index,
                       frame_value: frame_value, logical_address: logical_address};

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + CW'(in_accept && command == pat_pkg::CMD_TRANSLATE)
                         - CW'(out_pop);
    end
  end

  logic               dv;
  pat_pkg::div_work_t dw;

  pat_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_accept),
    .in_item   (in_item),
    .divisor   (page_size),
    .out_valid (dv),
    .out_work  (dw)
  );

  // range check: page_number < ceil(process/page) iff page_number*page < process
  logic              ps_zero;
  logic              err_d;
  logic [15:0]       widx;
  logic              is_write;
  logic              is_xlate;
  pat_pkg::tbl_req_t tbl_req;
  logic [7:0]        rd_data;

  assign ps_zero  = (page_size == '0);
  assign widx     = {9'b0, dw.item.page_index};
  assign is_write = dv && dw.item.command == pat_pkg::CMD_WRITE;
  assign is_xlate = dv && dw.item.command == pat_pkg::CMD_TRANSLATE;
  assign err_d    = ps_zero || (dw.quot >= DEPTH16)
                 || ((dw.item.logical_address - dw.rem) >= process_size);

  always_comb begin
    tbl_req.wr_en = is_write && (widx < DEPTH16);
    tbl_req.rd_en = is_xlate && !err_d;
    tbl_req.addr  = is_write ? widx : dw.quot;
    tbl_req.wdata = dw.item.frame_value;
  end

  pat_frame_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  logic        m_valid;
  logic [15:0] m_pnum;
  logic [15:0] m_poff;
  logic        m_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= is_xlate;
    end
  end

  always_ff @(posedge clk) begin
    m_pnum <= ps_zero ? '0 : dw.quot;
    m_poff <= ps_zero ? '0 : dw.rem;
    m_err  <= err_d;
  end

  logic [7:0]       m_frame;
  logic [23:0]      m_prod;
  pat_pkg::result_t res;
  pat_pkg::result_t head;

  assign m_frame = m_err ? 8'd0 : rd_data;
  assign m_prod  = {16'b0, m_frame} * {8'b0, page_size};

  always_comb begin
    res.page_number      = m_pnum;
    res.page_offset      = m_poff;
    res.frame_number     = m_frame;
    res.physical_address = m_err ? 24'd0 : m_prod + {8'b0, m_poff};
    res.out_of_range     = m_err;
  end

  pat_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (m_valid),
    .wdata (res),
    .pop   (out_pop),
    .valid (out_valid),
    .rdata (head)
  );

  assign page_number      = head.page_number;
  assign page_offset      = head.page_offset;
  assign frame_number     = head.frame_number;
  assign physical_address = head.physical_address;
  assign out_of_range     = head.out_of_range;

`ifndef SYNTHESIS
  a_credit_in_flight: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> credits != '0)
    else $error("translation in flight without a credit");

  a_ram_single_port: assert property (@(posedge clk) disable iff (rst)
    !(tbl_req.wr_en && tbl_req.rd_en))
    else $error("frame table write and read in one cycle");

  a_ram_addr_range: assert property (@(posedge clk) disable iff (rst)
    (tbl_req.wr_en || tbl_req.rd_en) |-> tbl_req.addr < DEPTH16)
    else $error("frame table access beyond depth");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> frame_number == '0 && physical_address == '0)
    else $error("error result carries a frame or address");
`endif

endmodule

>>> tb/pat_translation_checker.sv
`timescale 1ns / 1ps
// result checker for paged_address_translator_core: watches the register port and
// both item channels, predicts each translation and compares it field by field
// depends on pat_pkg only

module pat_translation_checker #(
  parameter int DEPTH = pat_pkg::TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [6:0]  page_index,
  input  logic [7:0]  frame_value,
  input  logic [15:0] logical_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] page_number,
  input  logic [15:0] page_offset,
  input  logic [7:0]  frame_number,
  input  logic [23:0] physical_address,
  input  logic        out_of_range,
  output int unsigned outstanding,
  output int unsigned mismatches
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       frames [DEPTH];
  logic [15:0]      page_size_q;
  logic [15:0]      process_size_q;
  pat_pkg::result_t awaited_translations [$];

  function automatic pat_pkg::result_t translate_address(input logic [15:0] laddr);
    pat_pkg::result_t r;
    int unsigned      ps;
    int unsigned      pages;
    r = '0;
    ps = page_size_q;
    if (ps == 0) begin
      r.out_of_range = 1'b1;
      return r;
    end
    r.page_number = 16'(laddr / ps);
    r.page_offset = 16'(laddr % ps);
    pages = (int'(process_size_q) + ps - 1) / ps;
    if (pages > DEPTH) pages = DEPTH;
    r.out_of_range = (r.page_number >= pages);
    if (!r.out_of_range) begin
      r.frame_number = frames[AW'(r.page_number)];
      r.physical_address = 24'(r.frame_number * ps + r.page_offset);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pat_pkg::result_t got;
    pat_pkg::result_t want;
    if (rst) begin
      awaited_translations.delete();
      page_size_q = 16'd1;
      process_size_q = 16'd0;
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == pat_pkg::CFG_PAGE_SIZE) page_size_q = cfg_data;
        else process_size_q = cfg_data;
      end
      if (out_valid && !out_stall) begin
        got = '{page_number, page_offset, frame_number, physical_address, out_of_range};
        if (awaited_translations.size() == 0) begin
          report_mismatch("result with no translation outstanding");
        end else begin
          want = awaited_translations.pop_front();
          if (got.page_number != want.page_number)
            report_mismatch($sformatf("page_number %0d, expected %0d",
                                      got.page_number, want.page_number));
          if (got.page_offset != want.page_offset)
            report_mismatch($sformatf("page_offset %0d, expected %0d",
                                      got.page_offset, want.page_offset));
          if (got.frame_number != want.frame_number)
            report_mismatch($sformatf("frame_number %0d, expected %0d",
                                      got.frame_number, want.frame_number));
          if (got.physical_address != want.physical_address)
            report_mismatch($sformatf("physical_address %0d, expected %0d",
                                      got.physical_address, want.physical_address));
          if (got.out_of_range != want.out_of_range)
            report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                      got.out_of_range, want.out_of_range));
        end
      end
      if (in_valid && !in_stall) begin
        if (command == pat_pkg::CMD_WRITE) begin
          if (page_index < DEPTH) frames[AW'(page_index)] = frame_value;
        end else begin
          awaited_translations.push_back(translate_address(logical_address));
        end
      end
      outstanding <= awaited_translations.size();
    end
  end

endmodule

>>> tb/tb_paged_address_translator_core.sv
`timescale 1ns / 1ps
// testbench top for paged_address_translator_core: directed and random items
// under several page and process sizes, verdict from pat_translation_checker
// depends on pat_pkg, the block and tb/pat_translation_checker.sv

module tb_paged_address_translator_core;

  localparam int LIMIT  = 200000;
  localparam int SETTLE = 24;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = pat_pkg::CFG_PAGE_SIZE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = pat_pkg::CMD_WRITE;
  logic [6:0]  page_index = '0;
  logic [7:0]  frame_value = '0;
  logic [15:0] logical_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] page_number;
  logic [15:0] page_offset;
  logic [7:0]  frame_number;
  logic [23:0] physical_address;
  logic        out_of_range;
  int unsigned outstanding;
  int unsigned mismatches;

  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          written [pat_pkg::TABLE_DEPTH];
  int unsigned ps_set = 1;
  int unsigned proc_set = 0;
  int unsigned writes_sent = 0;
  int unsigned translations_sent = 0;
  int unsigned settings = 0;

  paged_address_translator_core dut (.*);
  pat_translation_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d translations outstanding", cycles, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 19);

  function automatic int unsigned page_limit();
    int unsigned n;
    if (ps_set == 0) return 0;
    n = (proc_set + ps_set - 1) / ps_set;
    return (n > pat_pkg::TABLE_DEPTH) ? pat_pkg::TABLE_DEPTH : n;
  endfunction

  task automatic send_item(input logic cmd, input logic [6:0] idx, input logic [7:0] fval,
                           input logic [15:0] laddr);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    page_index <= idx;
    frame_value <= fval;
    logical_address <= laddr;
    do @(posedge clk); while (in_stall);
    if (cmd == pat_pkg::CMD_WRITE) begin
      written[idx] = 1'b1;
      writes_sent++;
    end else begin
      translations_sent++;
    end
  endtask

  task automatic write_entry(input logic [6:0] idx, input logic [7:0] fval);
    send_item(pat_pkg::CMD_WRITE, idx, fval, 16'($urandom_range(0, 65535)));
  endtask

  // a valid page that was never written gets an entry first
  task automatic translate(input logic [15:0] laddr);
    int unsigned pn;
    if (ps_set != 0) begin
      pn = laddr / ps_set;
      if (pn < page_limit() && !written[7'(pn)])
        write_entry(7'(pn), 8'($urandom_range(0, 255)));
    end
    send_item(pat_pkg::CMD_TRANSLATE, 7'($urandom_range(0, 127)),
              8'($urandom_range(0, 255)), laddr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned ps, input int unsigned proc);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= pat_pkg::CFG_PAGE_SIZE;
    cfg_data <= 16'(ps);
    @(posedge clk);
    cfg_index <= pat_pkg::CFG_PROCESS_SIZE;
    cfg_data <= 16'(proc);
    @(posedge clk);
    cfg_write <= 1'b0;
    ps_set = ps;
    proc_set = proc;
    settings++;
  endtask

  initial begin
    int          phase;
    int          n;
    int unsigned ps;
    int unsigned proc;
    int unsigned lim;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no valid page at all
    write_entry(7'd127, 8'd255);
    write_entry(7'd0, 8'd0);
    translate(16'd0);
    translate(16'hffff);

    // page count saturates at the table depth
    set_config(1, 65535);
    translate(16'd0);
    translate(16'd127);
    translate(16'd128);
    translate(16'hffff);
    write_entry(7'd5, 8'haa);
    translate(16'd5);

    // largest page, single page, largest physical address
    set_config(65535, 65535);
    write_entry(7'd0, 8'd255);
    translate(16'hfffe);
    translate(16'hffff);

    // zero page size
    set_config(0, 1234);
    translate(16'd0);
    translate(16'hffff);
    translate(16'h5555);

    // page size not a power of two, partial last page
    set_config(3, 200);
    translate(16'd200);
    translate(16'd201);
    translate(16'd199);

    set_config(7, 65535);
    translate(16'd895);
    translate(16'd896);

    for (phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 5))
        0: ps = $urandom_range(1, 8);
        1: ps = $urandom_range(9, 700);
        2: ps = $urandom_range(701, 65535);
        3: ps = (phase == 7) ? 0 : $urandom_range(0, 65535);
        default: ps = $urandom_range(1, 300);
      endcase
      case ($urandom_range(0, 3))
        0: proc = 0;
        1: proc = 65535;
        default: proc = $urandom_range(0, (ps * 130 + 1 > 65535) ? 65535 : ps * 130 + 1);
      endcase
      set_config(ps, proc);
      calm = (phase == 2);
      lim = (ps == 0) ? 65535 : page_limit() * ps + ps;
      if (lim > 65535) lim = 65535;
      for (n = 0; n < 100; n++) begin
        if (phase == 5 && n == 50) drain();
        if ($urandom_range(0, 99) < 30)
          write_entry(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 99) < 75)
          translate(16'($urandom_range(0, lim)));
        else
          translate(16'($urandom_range(0, 65535)));
      end
      calm = 1'b0;
    end

    drain();
    $display("covered %0d table writes and %0d translations over %0d register settings",
             writes_sent, translations_sent, settings);
    $display("page sizes 0, 1, 65535 and odd sizes; process sizes 0, 65535 and partial pages");
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
